### sv/pcp_pkg.sv
package pcp_pkg;

  localparam int unsigned EXP_SLOTS_DEF = 16;
  localparam int unsigned MAX_POWER_DEF = 8;

  localparam int unsigned COEF_W  = 16;
  localparam int unsigned EXP_W   = 4;
  localparam int unsigned POWER_W = 4;
  localparam int unsigned TGT_W   = 7;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_POWER  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'd1;

  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic [EXP_W-1:0]         exponent;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_coefficient;
    logic                     found;
  } out_item_t;

  typedef struct packed {
    logic en;
    logic last;
  } mac_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COPY,
    ST_CONV,
    ST_DRAIN,
    ST_RD,
    ST_FIN
  } state_e;

endpackage

### sv/pcp_ram.sv
module pcp_ram #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [pcp_pkg::DATA_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [pcp_pkg::DATA_W-1:0] rdata_o
);
  import pcp_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/pcp_mac.sv
module pcp_mac (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pcp_pkg::mac_ctrl_t         ctrl_i,
  input  logic [pcp_pkg::DATA_W-1:0] a_i,
  input  logic [pcp_pkg::DATA_W-1:0] b_i,
  output logic                       busy_o,
  output logic                       wr_valid_o,
  output logic [pcp_pkg::DATA_W-1:0] sum_o
);
  import pcp_pkg::*;

  mac_ctrl_t         ctrl_q;
  logic [DATA_W-1:0] prod_q;
  logic [DATA_W-1:0] acc_q;
  logic [DATA_W-1:0] sum;

  // low half of the product only: all arithmetic wraps at the word width
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign sum = acc_q + prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      acc_q  <= '0;
    end else begin
      ctrl_q <= ctrl_i;
      if (ctrl_q.en) begin
        // drop the sum after the last term of an output slot
        acc_q <= ctrl_q.last ? '0 : sum;
      end
    end
  end

  assign busy_o     = ctrl_q.en;
  assign wr_valid_o = ctrl_q.en && ctrl_q.last;
  assign sum_o      = sum;

endmodule

### sv/polynomial_power_coefficient.sv
// Polynomial power coefficient.
// Terms (coefficient, exponent) arrive on the input channel, one transfer per
// term, and are summed into a base store; the first term after a result starts
// a new polynomial. The term with last set raises the polynomial to the power
// register by repeated convolution (32-bit wrapping) and produces one transfer
// on the output channel: the coefficient at the target exponent and a found flag.
// Configuration: a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); write it
// only while the block is idle.
// A term without last is read and summed into the base store. A last term copies
// the store into the result memory and runs P-1 convolution rounds of RES*EXP_SLOTS
// products each, RES being (EXP_SLOTS-1)*MAX_POWER+1 and P the clamped power: one
// multiply-accumulate per cycle in the shared MAC within a round, bounded by the
// single result memory read port. It then reads the target slot from that memory.
// in_stall_o is high while an item is being worked on. The result sits in an
// output register; when out_stall_i holds it, terms of the next polynomial are
// still taken, and only the next last term waits for the register to drain.
// Reset (rst_ni, asynchronous, active low) sets power 1, target 0, empties the
// polynomial and drops any pending result.
module polynomial_power_coefficient #(
  parameter int unsigned EXP_SLOTS = pcp_pkg::EXP_SLOTS_DEF,
  parameter int unsigned MAX_POWER = pcp_pkg::MAX_POWER_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pcp_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pcp_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pcp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pcp_pkg::CFG_W-1:0]     cfg_data_i
);
  import pcp_pkg::*;

  localparam int unsigned RES_SLOTS = (EXP_SLOTS - 1) * MAX_POWER + 1;
  localparam int unsigned EW        = $clog2(EXP_SLOTS);
  localparam int unsigned RW        = $clog2(RES_SLOTS);
  localparam int unsigned PW        = $clog2(MAX_POWER + 1);
  localparam int unsigned RES_DEPTH = 2 << RW;
  localparam int unsigned MW        = PW + EXP_W;

  // configuration registers
  logic [POWER_W-1:0] power_q;
  logic [TGT_W-1:0]   tgt_q;

  // sequencer state
  state_e              state_q, state_d;
  logic                fp_q;
  logic [EXP_SLOTS-1:0] mask_q;
  logic [EXP_W-1:0]    low_q, high_q;
  logic [PW-1:0]       p_q, rounds_q, p_clamp;
  logic                src_q;
  logic                cv_q;
  logic [RW-1:0]       k_q;
  logic [EW-1:0]       j_q;
  in_item_t            item_q;

  // pipeline tags of the copy and convolution sweeps
  logic                p1_en_q, p1_vld_q, p1_last_q, p1_bm_q;
  logic [RW-1:0]       p1_k_q, p2_k_q;
  logic                cp_wr_q, cp_inb_q;
  logic [RW-1:0]       cp_k_q;

  // output register
  logic                out_vld_q;
  out_item_t           out_q;

  // memory ports
  logic                base_we, base_re;
  logic [EW-1:0]       base_waddr, base_raddr;
  logic [DATA_W-1:0]   base_wdata, base_rd;
  logic                res_we, res_re;
  logic [RW:0]         res_waddr, res_raddr;
  logic [DATA_W-1:0]   res_wdata, res_rd;

  // shared MAC
  mac_ctrl_t           mac_ctrl;
  logic [DATA_W-1:0]   mac_a, mac_b, mac_sum;
  logic                mac_busy, mac_wr;

  logic                in_acc, k_last, j_last, exp_ok, pipe_busy, out_load;
  logic [EW-1:0]       load_idx;
  logic [PW-1:0]       rounds_nx;
  logic                any_loaded, tgt_ok, found;
  logic [MW-1:0]       lo_prod, hi_prod;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign k_last   = (k_q == RW'(RES_SLOTS - 1));
  assign j_last   = (j_q == EW'(EXP_SLOTS - 1));
  assign load_idx = EW'(item_q.exponent);
  assign exp_ok   = (32'(item_q.exponent) < EXP_SLOTS);
  assign pipe_busy = cp_wr_q || p1_en_q || mac_busy;
  assign rounds_nx = cv_q ? rounds_q - PW'(1) : rounds_q;
  assign out_load = !out_vld_q || !out_stall_i;

  // power 0 behaves as 1, anything above the top saturates
  always_comb begin
    if (power_q == '0) begin
      p_clamp = PW'(1);
    end else if (32'(power_q) > MAX_POWER) begin
      p_clamp = PW'(MAX_POWER);
    end else begin
      p_clamp = PW'(power_q);
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= POWER_W'(1);
      tgt_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POWER:  power_q <= cfg_data_i[POWER_W-1:0];
        CFG_TARGET: tgt_q   <= cfg_data_i[TGT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state and memory port selection
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    base_re    = 1'b0;
    base_raddr = j_q;
    res_re     = 1'b0;
    res_raddr  = {src_q, k_q - RW'(j_q)};
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        base_raddr = EW'(in_data_i.exponent);
        base_re    = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (item_q.last) begin
          state_d = ST_COPY;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_COPY: begin
        base_re    = 1'b1;
        base_raddr = EW'(k_q);
        if (k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_CONV: begin
        base_re = 1'b1;
        res_re  = 1'b1;
        if (k_last && j_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait until every pending write has landed in the result memory
        if (!pipe_busy) begin
          state_d = (rounds_nx == '0) ? ST_RD : ST_CONV;
        end
      end
      ST_RD: begin
        res_re    = 1'b1;
        res_raddr = {src_q, RW'(tgt_q)};
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q     <= 1'b1;
      mask_q   <= '0;
      low_q    <= '0;
      high_q   <= '0;
      p_q      <= PW'(1);
      rounds_q <= '0;
      src_q    <= 1'b0;
      cv_q     <= 1'b0;
      k_q      <= '0;
      j_q      <= '0;
      p1_en_q  <= 1'b0;
      cp_wr_q  <= 1'b0;
    end else begin
      p1_en_q <= (state_q == ST_CONV);
      cp_wr_q <= (state_q == ST_COPY);
      case (state_q)
        ST_IDLE: begin
          // first term of a new polynomial empties the store
          if (in_acc && fp_q) begin
            mask_q <= '0;
            fp_q   <= 1'b0;
          end
        end
        ST_LOAD: begin
          if (exp_ok) begin
            mask_q[load_idx] <= 1'b1;
            if (~|mask_q) begin
              low_q  <= item_q.exponent;
              high_q <= item_q.exponent;
            end else begin
              if (item_q.exponent < low_q) begin
                low_q <= item_q.exponent;
              end
              if (item_q.exponent > high_q) begin
                high_q <= item_q.exponent;
              end
            end
          end
          if (item_q.last) begin
            p_q      <= p_clamp;
            rounds_q <= p_clamp - PW'(1);
            src_q    <= 1'b0;
            cv_q     <= 1'b0;
            k_q      <= '0;
            j_q      <= '0;
          end
        end
        ST_COPY: begin
          k_q <= k_last ? '0 : k_q + RW'(1);
        end
        ST_CONV: begin
          cv_q <= 1'b1;
          j_q  <= j_last ? '0 : j_q + EW'(1);
          if (j_last) begin
            k_q <= k_last ? '0 : k_q + RW'(1);
          end
        end
        ST_DRAIN: begin
          // a finished round swaps the banks
          if (!pipe_busy && cv_q) begin
            src_q    <= ~src_q;
            rounds_q <= rounds_nx;
            cv_q     <= 1'b0;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            fp_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and pipeline tags
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    p1_vld_q  <= (RW'(j_q) <= k_q);
    p1_last_q <= j_last;
    p1_bm_q   <= mask_q[j_q];
    p1_k_q    <= k_q;
    p2_k_q    <= p1_k_q;
    cp_inb_q  <= (32'(k_q) < EXP_SLOTS) && mask_q[EW'(k_q)];
    cp_k_q    <= k_q;
  end

  // base store: read-modify-write of one term
  assign base_we    = (state_q == ST_LOAD) && exp_ok;
  assign base_waddr = load_idx;
  assign base_wdata = (mask_q[load_idx] ? base_rd : '0) + DATA_W'(item_q.coefficient);

  pcp_ram #(
    .DEPTH (EXP_SLOTS)
  ) u_base_ram (
    .clk_i   (clk_i),
    .we_i    (base_we),
    .waddr_i (base_waddr),
    .wdata_i (base_wdata),
    .re_i    (base_re),
    .raddr_i (base_raddr),
    .rdata_o (base_rd)
  );

  // MAC operands: slots outside the polynomial contribute zero
  assign mac_a         = p1_vld_q ? res_rd : '0;
  assign mac_b         = p1_bm_q ? base_rd : '0;
  assign mac_ctrl.en   = p1_en_q;
  assign mac_ctrl.last = p1_last_q;

  pcp_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .a_i        (mac_a),
    .b_i        (mac_b),
    .busy_o     (mac_busy),
    .wr_valid_o (mac_wr),
    .sum_o      (mac_sum)
  );

  // result memory: two banks, copy writes bank zero, each round the other bank
  assign res_we    = cp_wr_q || mac_wr;
  assign res_waddr = cp_wr_q ? {1'b0, cp_k_q} : {~src_q, p2_k_q};
  assign res_wdata = cp_wr_q ? (cp_inb_q ? base_rd : '0) : mac_sum;

  pcp_ram #(
    .DEPTH (RES_DEPTH)
  ) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .re_i    (res_re),
    .raddr_i (res_raddr),
    .rdata_o (res_rd)
  );

  // found rule
  assign any_loaded = |mask_q;
  assign tgt_ok     = any_loaded && (32'(tgt_q) < RES_SLOTS);
  assign lo_prod    = MW'(p_q) * MW'(low_q);
  assign hi_prod    = MW'(p_q) * MW'(high_q);

  always_comb begin
    if (p_q == PW'(1)) begin
      found = (32'(tgt_q) < EXP_SLOTS) && mask_q[EW'(tgt_q)];
    end else begin
      found = (32'(tgt_q) >= 32'(lo_prod)) && (32'(tgt_q) <= 32'(hi_prod));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == ST_FIN && out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_load) begin
      out_q.result_coefficient <= tgt_ok ? res_rd : '0;
      out_q.found              <= tgt_ok && found;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // copy and MAC never share the write port
  a_wr_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cp_wr_q && mac_wr))
    else $error("result memory write port claimed twice");

  // a new result comes only from the final state
  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("result appeared outside the final state");

  // a convolution round runs only with rounds left
  a_rounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> (rounds_q != '0))
    else $error("convolution with no rounds left");

  // an accepted term is stored in the next cycle
  a_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_LOAD))
    else $error("accepted term not loaded");

endmodule
